### design/fwss_pkg.sv
// ----------------------------------------------------------------------------
// fwss_pkg: shared types and constants of the fixed-weight sparse sampler
// Beat formats, status codes, register map and the candidate mask helper.
// ----------------------------------------------------------------------------
`default_nettype none

package fwss_pkg;

  // Bitmap memory row geometry
  localparam int unsigned ROW_BITS  = 32;
  localparam int unsigned ROW_SEL_W = 5;

  // Register map (index = byte address / 4)
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_VECTOR_LENGTH = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_WEIGHT = 1'b1;

  localparam logic [15:0] VECTOR_LENGTH_RST = 16'd12323;
  localparam logic [15:0] TARGET_WEIGHT_RST = 16'd71;

  // Command codes
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEARED   = 3'd0,
    ST_ACCEPTED  = 3'd1,
    ST_RANGE     = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_IGNORED   = 3'd4
  } result_code_t;

  typedef enum logic [1:0] {
    SM_CLEAR,
    SM_IDLE,
    SM_RMW
  } sm_state_t;

  typedef struct packed {
    logic        command;
    logic [31:0] random_word;
  } in_item_t;

  typedef struct packed {
    result_code_t status;
    logic [14:0]  position;
    logic [15:0]  set_count;
    logic         complete;
  } out_item_t;

  typedef struct packed {
    logic [15:0] vector_length;
    logic [15:0] target_weight;
  } cfg_t;

  // All-ones mask covering the bit length of len
  function automatic logic [15:0] length_mask(input logic [15:0] len);
    logic [15:0] m;
    m = len;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    return m;
  endfunction

endpackage

`default_nettype wire

### design/fwss_cfg_regs.sv
// ----------------------------------------------------------------------------
// fwss_cfg_regs: APB-style configuration registers
// Holds vector length and target weight; zero-wait writes and reads.
// ----------------------------------------------------------------------------
`default_nettype none

module fwss_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [fwss_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [31:0]                        pwdata,
  output logic      [31:0]                        prdata,
  output logic                                    pready,
  output fwss_pkg::cfg_t                          cfg
);
  import fwss_pkg::*;

  logic [15:0]          vlen_r;
  logic [15:0]          weight_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1 -: REG_IDX_W];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r   <= VECTOR_LENGTH_RST;
      weight_r <= TARGET_WEIGHT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_VECTOR_LENGTH: vlen_r   <= pwdata[15:0];
        REG_TARGET_WEIGHT: weight_r <= pwdata[15:0];
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_VECTOR_LENGTH: prdata = {16'd0, vlen_r};
      REG_TARGET_WEIGHT: prdata = {16'd0, weight_r};
    endcase
  end

  assign cfg.vector_length = vlen_r;
  assign cfg.target_weight = weight_r;

endmodule

`default_nettype wire

### design/fwss_bitmap_ram.sv
// ----------------------------------------------------------------------------
// fwss_bitmap_ram: position bitmap storage
// Simple dual-port synchronous RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fwss_bitmap_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [AW-1:0]                 waddr,
  input  wire logic [fwss_pkg::ROW_BITS-1:0] wdata,
  input  wire logic                          re,
  input  wire logic [AW-1:0]                 raddr,
  output logic      [fwss_pkg::ROW_BITS-1:0] rdata
);
  import fwss_pkg::*;

  logic [ROW_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/fwss_ctrl.sv
// ----------------------------------------------------------------------------
// fwss_ctrl: sampler sequencer
// Clear sweep, candidate screening, bitmap read-modify-write, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fwss_ctrl #(
  parameter int unsigned MAX_LENGTH = 32768,
  parameter int unsigned ROWS       = 1024,
  parameter int unsigned ROW_AW     = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fwss_pkg::cfg_t                cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire fwss_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output fwss_pkg::out_item_t                out_data,
  output logic                               mem_we,
  output logic      [ROW_AW-1:0]             mem_waddr,
  output logic      [fwss_pkg::ROW_BITS-1:0] mem_wdata,
  output logic                               mem_re,
  output logic      [ROW_AW-1:0]             mem_raddr,
  input  wire logic [fwss_pkg::ROW_BITS-1:0] mem_rdata
);
  import fwss_pkg::*;

  localparam logic [16:0]       MAX_LEN_W = 17'(MAX_LENGTH);
  localparam logic [ROW_AW-1:0] LAST_ROW  = ROW_AW'(ROWS - 1);

  sm_state_t             state_r, state_nxt;
  logic [15:0]           cnt_r, cnt_nxt;
  logic [ROW_AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic                  clr_reply_r, clr_reply_nxt;
  logic                  out_valid_r;
  out_item_t             out_data_r;
  logic [ROW_AW-1:0]     row_r;
  logic [ROW_SEL_W-1:0]  bit_r;
  logic [14:0]           pos_r;

  logic [15:0]           eff_len;
  logic [15:0]           cand;
  logic                  done;
  logic [15:0]           cnt_inc;
  logic                  accept;
  logic                  load_out;
  out_item_t             res;

  // Candidate: masked word, effective length saturated at MAX_LENGTH
  always_comb begin
    if ({1'b0, cfg.vector_length} > MAX_LEN_W) begin
      eff_len = MAX_LEN_W[15:0];
    end else begin
      eff_len = cfg.vector_length;
    end
  end

  assign cand    = in_data.random_word[15:0] & length_mask(eff_len);
  assign done    = (cnt_r >= cfg.target_weight);
  assign cnt_inc = cnt_r + 16'd1;
  assign accept  = in_valid && in_ready;

  // Next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    clr_addr_nxt  = clr_addr_r;
    clr_reply_nxt = clr_reply_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_addr_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = ROW_AW'(cand >> ROW_SEL_W);
    load_out      = 1'b0;
    res           = '0;
    in_ready      = 1'b0;

    unique case (state_r)
      SM_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr_r == LAST_ROW) begin
          state_nxt    = SM_IDLE;
          clr_addr_nxt = '0;
          if (clr_reply_r) begin
            load_out      = 1'b1;
            res.status    = ST_CLEARED;
            res.set_count = cnt_r;
            res.complete  = (cfg.target_weight == 16'd0);
            clr_reply_nxt = 1'b0;
          end
        end else begin
          clr_addr_nxt = clr_addr_r + ROW_AW'(1);
        end
      end

      SM_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        if (in_valid && in_ready) begin
          if (in_data.command == CMD_START) begin
            cnt_nxt       = '0;
            clr_reply_nxt = 1'b1;
            state_nxt     = SM_CLEAR;
          end else if (done) begin
            load_out      = 1'b1;
            res.status    = ST_IGNORED;
            res.set_count = cnt_r;
            res.complete  = 1'b1;
          end else if (cand >= eff_len) begin
            load_out      = 1'b1;
            res.status    = ST_RANGE;
            res.position  = cand[14:0];
            res.set_count = cnt_r;
            res.complete  = done;
          end else begin
            mem_re    = 1'b1;
            state_nxt = SM_RMW;
          end
        end
      end

      SM_RMW: begin
        load_out     = 1'b1;
        res.position = pos_r;
        state_nxt    = SM_IDLE;
        if (mem_rdata[bit_r]) begin
          res.status    = ST_DUPLICATE;
          res.set_count = cnt_r;
          res.complete  = done;
        end else begin
          mem_we        = 1'b1;
          mem_waddr     = row_r;
          mem_wdata     = mem_rdata | (ROW_BITS'(1) << bit_r);
          cnt_nxt       = cnt_inc;
          res.status    = ST_ACCEPTED;
          res.set_count = cnt_inc;
          res.complete  = (cnt_inc >= cfg.target_weight);
        end
      end

      default: begin
        state_nxt = SM_CLEAR;
      end
    endcase
  end

  // Control state; reset starts a full clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SM_CLEAR;
      cnt_r       <= '0;
      clr_addr_r  <= '0;
      clr_reply_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_reply_r <= clr_reply_nxt;
    end
  end

  // Candidate held across the read-modify-write
  always_ff @(posedge clk) begin
    if (accept) begin
      row_r <= ROW_AW'(cand >> ROW_SEL_W);
      bit_r <= cand[ROW_SEL_W-1:0];
      pos_r <= cand[14:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### design/fixed_weight_sparse_sampler_unit.sv
// ----------------------------------------------------------------------------
// fixed_weight_sparse_sampler_unit: fixed-weight sparse vector sampler
// Usage:
//   in_*  : valid/ready beat {command, random_word}. command 0 starts a new
//           vector, command 1 offers one random word for rejection sampling.
//   out_* : valid/ready beat {status, position, set_count, complete}, one per
//           input beat, in order.
//   APB   : register 0 (0x0) vector_length, register 1 (0x4) target_weight.
// Timing:
//   A word that is ignored or out of range has its result registered in the
//   cycle after acceptance. A candidate inside the vector reads its bitmap row,
//   then sets its bit if new while the result is registered.
//   A start beat sweeps the bitmap memory one 32-bit row per cycle over all
//   ceil(MAX_LENGTH/32) rows (1024 at the default), then returns its result.
// Reset: the same clearing sweep runs after reset, with in_ready low.
// Stall: one result register; while it is full and out_ready is low, no new
//   input beat is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_weight_sparse_sampler_unit #(
  parameter int unsigned MAX_LENGTH = 32768
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire fwss_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output fwss_pkg::out_item_t                   out_data,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [fwss_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready
);
  import fwss_pkg::*;

  localparam int unsigned ROWS   = (MAX_LENGTH + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  cfg_t                cfg;
  logic                mem_we;
  logic [ROW_AW-1:0]   mem_waddr;
  logic [ROW_BITS-1:0] mem_wdata;
  logic                mem_re;
  logic [ROW_AW-1:0]   mem_raddr;
  logic [ROW_BITS-1:0] mem_rdata;

  fwss_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fwss_ctrl #(
    .MAX_LENGTH (MAX_LENGTH),
    .ROWS       (ROWS),
    .ROW_AW     (ROW_AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  fwss_bitmap_ram #(
    .DEPTH (ROWS),
    .AW    (ROW_AW)
  ) u_bitmap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

### design/fwss_checker.sv
// ----------------------------------------------------------------------------
// fwss_checker: port-level assertions for the sampler
// Checks reset behavior, result stability and status/field consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module fwss_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire fwss_pkg::out_item_t out_data
);
  import fwss_pkg::*;

  // Reset empties the result register and starts the clearing sweep
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("beat activity right after reset");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // A fresh vector reports an empty count
  a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_CLEARED |->
      out_data.set_count == 16'd0 && out_data.position == 15'd0)
    else $error("cleared beat with nonzero fields");

  // Ignored words only once complete
  a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_IGNORED |->
      out_data.complete && out_data.position == 15'd0)
    else $error("ignored beat while incomplete");

  // An accepted position always leaves a nonzero count
  a_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_ACCEPTED |-> out_data.set_count != 16'd0)
    else $error("accepted beat with zero count");

endmodule

bind fixed_weight_sparse_sampler_unit fwss_checker u_fwss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
